@@ rtl/dtf_pkg.sv @@
// Shared widths, codes and types of the degenerate triangle filter.
`default_nettype none
package dtf_pkg;

    localparam int INDEX_WIDTH_DEF = 32;
    localparam int COORD_FRAC_DEF  = 24;

    localparam int IDX_W    = 32;
    localparam int COORD_W  = 40;
    localparam int TOL_W    = 39;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = COORD_W;
    localparam int HALF_W   = MAG_W / 2;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int CR_W     = PROD_W + 1;
    localparam int LIMB_W   = CR_W / 3;
    localparam int SQ_W     = 2 * CR_W;
    localparam int LEN_W    = SQ_W + 2;
    localparam int TOL_LO_W = (TOL_W + 1) / 2;
    localparam int TOL_HI_W = TOL_W - TOL_LO_W;
    localparam int ASQ_W    = 2 * TOL_W;

    localparam logic [TOL_W-1:0] POS_TOL_RST  = TOL_W'(17);
    localparam logic [TOL_W-1:0] AREA_TOL_RST = TOL_W'(1678);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOL = 1'b1;

    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic signed [COORD_W-1:0]     coord_t;
    typedef logic [2:0][COORD_W-1:0]       vec3_t;
    typedef logic [2:0][DIFF_W-1:0]        diff3_t;
    typedef logic [2:0][MAG_W-1:0]         mag3_t;
    typedef logic [2:0][CR_W-1:0]          cr3_t;

    // control that travels beside the datapath
    typedef struct packed {
        logic valid;
        logic keep;
        idx_t a;
        idx_t b;
        idx_t c;
    } tag_t;

    // edge vector in sign/magnitude form
    typedef struct packed {
        logic [2:0] sgn;
        mag3_t      mag;
    } evec_t;

endpackage
`default_nettype wire

@@ rtl/dtf_if.sv @@
// Stream interfaces: triangle input word and kept-index output word.
`default_nettype none
interface dtf_tri_if;
    logic            valid;
    logic            ready;
    dtf_pkg::idx_t   idx_a;
    dtf_pkg::idx_t   idx_b;
    dtf_pkg::idx_t   idx_c;
    dtf_pkg::coord_t ax;
    dtf_pkg::coord_t ay;
    dtf_pkg::coord_t az;
    dtf_pkg::coord_t bx;
    dtf_pkg::coord_t by_coord;
    dtf_pkg::coord_t bz;
    dtf_pkg::coord_t cx;
    dtf_pkg::coord_t cy;
    dtf_pkg::coord_t cz;

    modport source (
        output valid, idx_a, idx_b, idx_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        input  ready
    );
    modport sink (
        input  valid, idx_a, idx_b, idx_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
        output ready
    );
endinterface

interface dtf_idx_if;
    logic          valid;
    logic          ready;
    dtf_pkg::idx_t out_idx_a;
    dtf_pkg::idx_t out_idx_b;
    dtf_pkg::idx_t out_idx_c;

    modport source (
        output valid, out_idx_a, out_idx_b, out_idx_c,
        input  ready
    );
    modport sink (
        input  valid, out_idx_a, out_idx_b, out_idx_c,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/degenerate_triangle_filter.sv @@
// Degenerate triangle filter top level: passes on the indices of non-degenerate triangles.
// Pipeline: 11 register stages, the last being the output word register. Dropped
//   triangles produce no output word.
// Throughput: one triangle per cycle; a stall at the output freezes all stages at once.
// Reset (rst_n, async, active low) empties the pipeline and loads the default tolerances.
// A new area tolerance reaches thr via the product registers and thr_reg in dtf_thresh.
`default_nettype none
module degenerate_triangle_filter #(
    parameter int INDEX_WIDTH     = dtf_pkg::INDEX_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = dtf_pkg::COORD_FRAC_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dtf_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [dtf_pkg::TOL_W-1:0]       cfg_wdata,
    dtf_tri_if.sink                              tri_in,
    dtf_idx_if.source                            tri_out
);

    localparam int IW = dtf_pkg::IDX_W;
    localparam int TW = dtf_pkg::TOL_W;
    // indices are compared and passed on in their low INDEX_WIDTH bits
    localparam logic [IW-1:0] IDX_MASK = IW'((64'd1 << INDEX_WIDTH) - 64'd1);

    // ---------------------------------------------------------------
    // Tolerance registers
    // ---------------------------------------------------------------
    logic [TW-1:0] pos_tol_reg;
    logic [TW-1:0] area_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_tol_reg  <= dtf_pkg::POS_TOL_RST;
            area_tol_reg <= dtf_pkg::AREA_TOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                dtf_pkg::CFG_POS_TOL:  pos_tol_reg  <= cfg_wdata;
                dtf_pkg::CFG_AREA_TOL: area_tol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global pipeline advance: every stage moves unless the output word
    // is held. Empty stages and dropped triangles simply ride along.
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic en;

    assign en           = ~out_valid_reg | tri_out.ready;
    assign tri_in.ready = en;

    dtf_pkg::tag_t  tag_in;
    dtf_pkg::vec3_t pa, pb, pc;

    always_comb begin
        tag_in.valid = tri_in.valid;
        tag_in.keep  = 1'b0;            // set by the index check in stage 1
        tag_in.a     = tri_in.idx_a & IDX_MASK;
        tag_in.b     = tri_in.idx_b & IDX_MASK;
        tag_in.c     = tri_in.idx_c & IDX_MASK;
    end

    assign pa = {tri_in.az, tri_in.ay,       tri_in.ax};
    assign pb = {tri_in.bz, tri_in.by_coord, tri_in.bx};
    assign pc = {tri_in.cz, tri_in.cy,       tri_in.cx};

    // Stages 1-2: index distinctness, edges e1 = b-a, e2 = c-a, and the
    // coincident-vertex test for all three vertex pairs.
    dtf_pkg::tag_t  tag_f;
    dtf_pkg::evec_t e1, e2;

    dtf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .pos_tol (pos_tol_reg),
        .tag_in  (tag_in),
        .pa      (pa),
        .pb      (pb),
        .pc      (pc),
        .tag_out (tag_f),
        .e1      (e1),
        .e2      (e2)
    );

    // Stages 3-5: cross product e1 x e2, magnitude per axis.
    dtf_pkg::tag_t tag_c;
    dtf_pkg::cr3_t cr;

    dtf_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (tag_f),
        .e1      (e1),
        .e2      (e2),
        .tag_out (tag_c),
        .cr      (cr)
    );

    // Stages 6-10: exact squared length of the cross product.
    dtf_pkg::tag_t                tag_n;
    logic [dtf_pkg::LEN_W-1:0]    len2;

    dtf_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (tag_c),
        .cr      (cr),
        .tag_out (tag_n),
        .len2    (len2)
    );

    // Threshold runs freely off the area tolerance register.
    logic [dtf_pkg::LEN_W-1:0] thr;

    dtf_thresh #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_thresh (
        .clk      (clk),
        .area_tol (area_tol_reg),
        .thr      (thr)
    );

    // ---------------------------------------------------------------
    // Stage 11: area compare and output word register. Equal to the
    // threshold counts as degenerate.
    // ---------------------------------------------------------------
    logic          out_valid_next;
    logic [IW-1:0] out_a_reg, out_b_reg, out_c_reg;

    assign out_valid_next = tag_n.valid & tag_n.keep & (len2 > thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_a_reg <= tag_n.a;
            out_b_reg <= tag_n.b;
            out_c_reg <= tag_n.c;
        end
    end

    assign tri_out.valid     = out_valid_reg;
    assign tri_out.out_idx_a = out_a_reg;
    assign tri_out.out_idx_b = out_b_reg;
    assign tri_out.out_idx_c = out_c_reg;

endmodule
`default_nettype wire

@@ rtl/dtf_front.sv @@
// Front stages: index check, edge differences, position tolerance test.
`default_nettype none
module dtf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [dtf_pkg::TOL_W-1:0]     pos_tol,
    input  wire dtf_pkg::tag_t                 tag_in,
    input  wire dtf_pkg::vec3_t                pa,
    input  wire dtf_pkg::vec3_t                pb,
    input  wire dtf_pkg::vec3_t                pc,
    output dtf_pkg::tag_t                      tag_out,
    output dtf_pkg::evec_t                     e1,
    output dtf_pkg::evec_t                     e2
);

    localparam int CW = dtf_pkg::COORD_W;
    localparam int DW = dtf_pkg::DIFF_W;
    localparam int MW = dtf_pkg::MAG_W;

    function automatic logic [MW-1:0] abs_diff(input logic [DW-1:0] d);
        logic [DW-1:0] n;
        n = -d;
        return d[DW-1] ? n[MW-1:0] : d[MW-1:0];
    endfunction

    function automatic logic all_within(input dtf_pkg::mag3_t m, input logic [MW-1:0] t);
        logic r;
        r = 1'b1;
        for (int k = 0; k < 3; k++) begin
            r = r & (m[k] <= t);
        end
        return r;
    endfunction

    // stage 1
    dtf_pkg::tag_t   tag1_reg, tag1_next;
    dtf_pkg::diff3_t d1_reg, d1_next;   // b - a
    dtf_pkg::diff3_t d2_reg, d2_next;   // c - a
    dtf_pkg::diff3_t d3_reg, d3_next;   // c - b

    always_comb begin
        tag1_next      = tag_in;
        tag1_next.keep = (tag_in.a != tag_in.b) && (tag_in.b != tag_in.c) &&
                         (tag_in.a != tag_in.c);
        for (int k = 0; k < 3; k++) begin
            d1_next[k] = {pb[k][CW-1], pb[k]} - {pa[k][CW-1], pa[k]};
            d2_next[k] = {pc[k][CW-1], pc[k]} - {pa[k][CW-1], pa[k]};
            d3_next[k] = {pc[k][CW-1], pc[k]} - {pb[k][CW-1], pb[k]};
        end
    end

    // stage 2
    dtf_pkg::tag_t   tag2_reg, tag2_next;
    dtf_pkg::evec_t  e1_reg, e1_next;
    dtf_pkg::evec_t  e2_reg, e2_next;
    dtf_pkg::mag3_t  m3;
    logic [MW-1:0]   tol_ext;
    logic            near_any;

    always_comb begin
        tol_ext = MW'(pos_tol);
        for (int k = 0; k < 3; k++) begin
            e1_next.mag[k] = abs_diff(d1_reg[k]);
            e1_next.sgn[k] = d1_reg[k][DW-1];
            e2_next.mag[k] = abs_diff(d2_reg[k]);
            e2_next.sgn[k] = d2_reg[k][DW-1];
            m3[k]          = abs_diff(d3_reg[k]);
        end
        near_any = all_within(e1_next.mag, tol_ext) || all_within(e2_next.mag, tol_ext) ||
                   all_within(m3, tol_ext);
        tag2_next      = tag1_reg;
        tag2_next.keep = tag1_reg.keep & ~near_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
    end

    assign tag_out = tag2_reg;
    assign e1      = e1_reg;
    assign e2      = e2_reg;

endmodule
`default_nettype wire

@@ rtl/dtf_cross.sv @@
// Cross product stages: split partial products, product sums, signed combine.
`default_nettype none
module dtf_cross (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire dtf_pkg::tag_t  tag_in,
    input  wire dtf_pkg::evec_t e1,
    input  wire dtf_pkg::evec_t e2,
    output dtf_pkg::tag_t       tag_out,
    output dtf_pkg::cr3_t       cr
);

    localparam int MW    = dtf_pkg::MAG_W;
    localparam int HW    = dtf_pkg::HALF_W;
    localparam int PW    = dtf_pkg::PROD_W;
    localparam int CRW   = dtf_pkg::CR_W;
    localparam int MID_W = MW + 1;
    localparam int NP    = 6;
    localparam int PP_HH = 0;
    localparam int PP_HL = 1;
    localparam int PP_LH = 2;
    localparam int PP_LL = 3;

    logic [MW-1:0] pp_reg  [NP][4];
    logic [MW-1:0] pp_next [NP][4];
    logic [NP-1:0] sg3_reg, sg3_next;
    logic [PW-1:0] p_reg   [NP];
    logic [PW-1:0] p_next  [NP];
    logic [NP-1:0] sg4_reg;
    dtf_pkg::cr3_t cr_reg, cr_next;
    dtf_pkg::tag_t tag3_reg, tag4_reg, tag5_reg;

    // cr[k] = e1[k+1]*e2[k+2] - e1[k+2]*e2[k+1]; even products positive
    for (genvar p = 0; p < NP; p++) begin : g_prod
        localparam int K  = p / 2;
        localparam int I1 = (p % 2 == 0) ? (K + 1) % 3 : (K + 2) % 3;
        localparam int I2 = (p % 2 == 0) ? (K + 2) % 3 : (K + 1) % 3;
        logic [HW-1:0]    ah, al, bh, bl;
        logic [MID_W-1:0] mid;

        assign ah = e1.mag[I1][MW-1:HW];
        assign al = e1.mag[I1][HW-1:0];
        assign bh = e2.mag[I2][MW-1:HW];
        assign bl = e2.mag[I2][HW-1:0];
        assign pp_next[p][PP_HH] = ah * bh;
        assign pp_next[p][PP_HL] = ah * bl;
        assign pp_next[p][PP_LH] = al * bh;
        assign pp_next[p][PP_LL] = al * bl;
        assign sg3_next[p]       = e1.sgn[I1] ^ e2.sgn[I2];

        assign mid       = MID_W'(pp_reg[p][PP_HL]) + MID_W'(pp_reg[p][PP_LH]);
        assign p_next[p] = {pp_reg[p][PP_HH], pp_reg[p][PP_LL]} +
                           PW'({mid, {HW{1'b0}}});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 4; j++) begin
                    pp_reg[p][j] <= pp_next[p][j];
                end
                p_reg[p] <= p_next[p];
            end
        end
    end

    // |s1*P1 - s2*P2|: sum when signs differ, absolute difference otherwise
    for (genvar k = 0; k < 3; k++) begin : g_comb
        logic [CRW-1:0] sum, dif, neg;
        assign sum = CRW'(p_reg[2*k]) + CRW'(p_reg[2*k+1]);
        assign dif = CRW'(p_reg[2*k]) - CRW'(p_reg[2*k+1]);
        assign neg = CRW'(p_reg[2*k+1]) - CRW'(p_reg[2*k]);
        assign cr_next[k] = (sg4_reg[2*k] != sg4_reg[2*k+1]) ? sum :
                            (dif[CRW-1] ? neg : dif);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else if (en)
        begin
            tag3_reg <= tag_in;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg3_reg <= sg3_next;
            sg4_reg <= sg3_reg;
            cr_reg  <= cr_next;
        end
    end

    assign tag_out = tag5_reg;
    assign cr      = cr_reg;

endmodule
`default_nettype wire

@@ rtl/dtf_norm.sv @@
// Squared length stages: limb squares, cross terms, per-axis squares, sum.
`default_nettype none
module dtf_norm (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire dtf_pkg::tag_t              tag_in,
    input  wire dtf_pkg::cr3_t              cr,
    output dtf_pkg::tag_t                   tag_out,
    output logic [dtf_pkg::LEN_W-1:0]       len2
);

    localparam int LW   = dtf_pkg::LIMB_W;
    localparam int PPW  = 2 * LW;
    localparam int XS_W = 4 * LW + 1;
    localparam int SQW  = dtf_pkg::SQ_W;
    localparam int LNW  = dtf_pkg::LEN_W;
    localparam int NT   = 5;
    localparam int Q_LL = 0;
    localparam int Q_MM = 1;
    localparam int Q_HH = 2;
    localparam int Q_LM = 3;
    localparam int Q_LH = 4;
    localparam int Q_MH = 5;

    logic [PPW-1:0]  q_reg    [3][6];
    logic [PPW-1:0]  q_next   [3][6];
    logic [SQW-1:0]  base_reg [3];
    logic [XS_W-1:0] xs_reg   [3];
    logic [XS_W-1:0] xs_next  [3];
    logic [SQW-1:0]  sq_reg   [3];
    logic [SQW-1:0]  sq_next  [3];
    logic [LNW-1:0]  sxy_reg, sxy_next;
    logic [SQW-1:0]  sqz_reg;
    logic [LNW-1:0]  len2_reg, len2_next;
    dtf_pkg::tag_t   tag_reg [NT];

    for (genvar k = 0; k < 3; k++) begin : g_sq
        logic [LW-1:0] l, m, h;
        assign l = cr[k][LW-1:0];
        assign m = cr[k][2*LW-1:LW];
        assign h = cr[k][3*LW-1:2*LW];
        assign q_next[k][Q_LL] = l * l;
        assign q_next[k][Q_MM] = m * m;
        assign q_next[k][Q_HH] = h * h;
        assign q_next[k][Q_LM] = l * m;
        assign q_next[k][Q_LH] = l * h;
        assign q_next[k][Q_MH] = m * h;

        // cross terms relative to weight 2^LW; doubled when added to the base
        assign xs_next[k] = XS_W'({q_reg[k][Q_MH], q_reg[k][Q_LM]}) +
                            XS_W'({q_reg[k][Q_LH], {LW{1'b0}}});
        assign sq_next[k] = base_reg[k] + SQW'({xs_reg[k], {(LW + 1){1'b0}}});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 6; j++) begin
                    q_reg[k][j] <= q_next[k][j];
                end
                base_reg[k] <= {q_reg[k][Q_HH], q_reg[k][Q_MM], q_reg[k][Q_LL]};
                xs_reg[k]   <= xs_next[k];
                sq_reg[k]   <= sq_next[k];
            end
        end
    end

    assign sxy_next  = LNW'(sq_reg[0]) + LNW'(sq_reg[1]);
    assign len2_next = sxy_reg + LNW'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++) begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < NT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxy_reg  <= sxy_next;
            sqz_reg  <= sq_reg[2];
            len2_reg <= len2_next;
        end
    end

    assign tag_out = tag_reg[NT-1];
    assign len2    = len2_reg;

endmodule
`default_nettype wire

@@ rtl/dtf_thresh.sv @@
// Area threshold: (2*area_tol)^2 scaled to the squared cross product's format.
`default_nettype none
module dtf_thresh #(
    parameter int COORD_FRAC_BITS = dtf_pkg::COORD_FRAC_DEF
) (
    input  wire logic                       clk,
    input  wire logic [dtf_pkg::TOL_W-1:0]  area_tol,
    output logic [dtf_pkg::LEN_W-1:0]       thr
);

    localparam int LOW   = dtf_pkg::TOL_LO_W;
    localparam int HIW   = dtf_pkg::TOL_HI_W;
    localparam int TW    = dtf_pkg::TOL_W;
    localparam int AW    = dtf_pkg::ASQ_W;
    localparam int LNW   = dtf_pkg::LEN_W;
    localparam int SHIFT = 2 * COORD_FRAC_BITS + 2;

    logic [HIW-1:0]       th, th_l;
    logic [LOW-1:0]       tl;
    logic [2*HIW-1:0]     hh_reg, hh_next;
    logic [HIW+LOW-1:0]   hl_reg, hl_next;
    logic [2*LOW-1:0]     ll_reg, ll_next;
    logic [AW-1:0]        asq;
    logic [LNW-1:0]       thr_reg, thr_next;

    assign th      = area_tol[TW-1:LOW];
    assign th_l    = th;
    assign tl      = area_tol[LOW-1:0];
    assign hh_next = th * th_l;
    assign hl_next = th * tl;
    assign ll_next = tl * tl;

    assign asq      = AW'({hh_reg, ll_reg}) + AW'({hl_reg, {(LOW + 1){1'b0}}});
    assign thr_next = LNW'(asq) << SHIFT;

    always_ff @(posedge clk)
    begin
        hh_reg  <= hh_next;
        hl_reg  <= hl_next;
        ll_reg  <= ll_next;
        thr_reg <= thr_next;
    end

    assign thr = thr_reg;

endmodule
`default_nettype wire
